/* sv/pesp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pesp_pkg
// Shared types and constants for the PES header strip parser.
// ----------------------------------------------------------------------------
package pesp_pkg;

  // Start code bytes 00 00 01
  localparam logic [7:0] ScByteZero = 8'h00;
  localparam logic [7:0] ScByteOne  = 8'h01;

  // Stream ids with special handling
  localparam logic [7:0] SidMap      = 8'hbc;
  localparam logic [7:0] SidPadding  = 8'hbe;
  localparam logic [7:0] SidPrivate2 = 8'hbf;
  localparam logic [7:0] SidEcm      = 8'hf0;
  localparam logic [7:0] SidEmm      = 8'hf1;
  localparam logic [7:0] SidDsmcc    = 8'hf2;
  localparam logic [7:0] SidH2221E   = 8'hf8;
  localparam logic [7:0] SidDir      = 8'hff;

  // Depth of the queue between parser and output side
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One result item
  typedef struct packed {
    logic       start_code_error;
    logic       had_flags;
    logic       payload_first;
    logic [7:0] stream_id;
    logic [7:0] payload_byte;
  } result_t;

  // Streams that carry no optional header flag bytes
  function automatic logic no_flag_stream(input logic [7:0] sid);
    return (sid == SidMap) || (sid == SidPrivate2) || (sid == SidEcm) ||
           (sid == SidEmm) || (sid == SidDsmcc) || (sid == SidH2221E) ||
           (sid == SidDir);
  endfunction

endpackage
`default_nettype wire

/* sv/pes_header_strip_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pes_header_strip_parser_unit
// Strips PES headers from a byte stream and emits tagged payload bytes and start code errors.
// ----------------------------------------------------------------------------
//  Channel  | Dir | tdata                         | tuser
//  s_axis   | in  | [7:0] data_byte               | [0] pkt_start
//  m_axis   | out | [7:0] payload_byte,           | [0] payload_first,
//           |     | [15:8] stream_id              | [1] had_flags,
//           |     |                               | [2] start_code_error
//
// One input byte per cycle while s_axis_tready_o is high; each byte is parsed
// in the cycle it is accepted and its result (if any) lands in a two-entry
// queue, so the first result appears on m_axis in the cycle after its byte.
// s_axis_tready_o drops only while the queue holds two results, which happens
// when m_axis stalls while results arrive back to back.
// Reset clears the parser to idle (waiting for a unit start) and empties the
// queue; bytes before the first unit start are dropped.
// ----------------------------------------------------------------------------
module pes_header_strip_parser_unit
  import pesp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] pkt_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] payload_byte, [15:8] stream_id
  output logic [2:0]       m_axis_tuser_o    // [0] payload_first, [1] had_flags,
                                             // [2] start_code_error
);

  logic    accept;
  logic    push;
  logic    full;
  result_t result;
  result_t head;

  // Take a transaction whenever the queue can hold its possible result
  assign s_axis_tready_o = ~full;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // Front: byte parser and classifier
  pesp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pkt_start_i  (s_axis_tuser_i),
    .data_byte_i  (s_axis_tdata_i),
    .result_o     (result),
    .push_o       (push)
  );

  // Back: result queue feeding the output transaction
  pesp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .full_o      (full),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .head_o      (head)
  );

  assign m_axis_tdata_o = {head.stream_id, head.payload_byte};
  assign m_axis_tuser_o = {head.start_code_error, head.had_flags, head.payload_first};

endmodule
`default_nettype wire

/* sv/pesp_parse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pesp_parse
// Byte state machine: checks start code, reads header, classifies bytes.
// ----------------------------------------------------------------------------
module pesp_parse
  import pesp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       pkt_start_i,
  input  wire logic [7:0] data_byte_i,
  output result_t         result_o,
  output logic            push_o
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhSc2     = 4'd1;
  localparam logic [3:0] PhSc3     = 4'd2;
  localparam logic [3:0] PhSid     = 4'd3;
  localparam logic [3:0] PhLenHi   = 4'd4;
  localparam logic [3:0] PhLenLo   = 4'd5;
  localparam logic [3:0] PhFlag1   = 4'd6;
  localparam logic [3:0] PhFlag2   = 4'd7;
  localparam logic [3:0] PhHdrLen  = 4'd8;
  localparam logic [3:0] PhHdrSkip = 4'd9;
  localparam logic [3:0] PhPayload = 4'd10;

  logic [3:0] phase_q, phase_d;
  logic [7:0] stream_q, stream_d;
  logic [7:0] skip_q, skip_d;
  logic       first_q, first_d;
  logic       flags_q, flags_d;

  always_comb begin
    phase_d  = phase_q;
    stream_d = stream_q;
    skip_d   = skip_q;
    first_d  = first_q;
    flags_d  = flags_q;
    push_o   = 1'b0;
    result_o = '0;
    if (accept_i) begin
      if (pkt_start_i) begin
        stream_d = '0;
        skip_d   = '0;
        first_d  = 1'b0;
        flags_d  = 1'b0;
        if (data_byte_i != ScByteZero) begin
          push_o                    = 1'b1;
          result_o.start_code_error = 1'b1;
          phase_d                   = PhIdle;
        end else begin
          phase_d = PhSc2;
        end
      end else begin
        case (phase_q)
          PhSc2: begin
            if (data_byte_i != ScByteZero) begin
              push_o                    = 1'b1;
              result_o.start_code_error = 1'b1;
              phase_d                   = PhIdle;
            end else begin
              phase_d = PhSc3;
            end
          end
          PhSc3: begin
            if (data_byte_i != ScByteOne) begin
              push_o                    = 1'b1;
              result_o.start_code_error = 1'b1;
              phase_d                   = PhIdle;
            end else begin
              phase_d = PhSid;
            end
          end
          PhSid: begin
            stream_d = data_byte_i;
            phase_d  = PhLenHi;
          end
          PhLenHi: begin
            phase_d = PhLenLo;
          end
          PhLenLo: begin
            if (stream_q == SidPadding) begin
              phase_d = PhIdle;
            end else if (no_flag_stream(stream_q)) begin
              flags_d = 1'b0;
              first_d = 1'b1;
              phase_d = PhPayload;
            end else begin
              flags_d = 1'b1;
              phase_d = PhFlag1;
            end
          end
          PhFlag1: begin
            phase_d = PhFlag2;
          end
          PhFlag2: begin
            phase_d = PhHdrLen;
          end
          PhHdrLen: begin
            skip_d = data_byte_i;
            if (data_byte_i == 8'd0) begin
              first_d = 1'b1;
              phase_d = PhPayload;
            end else begin
              phase_d = PhHdrSkip;
            end
          end
          PhHdrSkip: begin
            skip_d = skip_q - 8'd1;
            if (skip_q == 8'd1) begin
              first_d = 1'b1;
              phase_d = PhPayload;
            end
          end
          PhPayload: begin
            push_o                 = 1'b1;
            result_o.payload_byte  = data_byte_i;
            result_o.stream_id     = stream_q;
            result_o.payload_first = first_q;
            result_o.had_flags     = flags_q;
            first_d                = 1'b0;
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      stream_q <= '0;
      skip_q   <= '0;
      first_q  <= 1'b0;
      flags_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      stream_q <= stream_d;
      skip_q   <= skip_d;
      first_q  <= first_d;
      flags_q  <= flags_d;
    end
  end

endmodule
`default_nettype wire

/* sv/pesp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pesp_queue
// Short result queue; its head drives the output stream.
// ----------------------------------------------------------------------------
module pesp_queue
  import pesp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t push_data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      head_o
);

  result_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;
  logic                  pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire
